FILE: src/assert_macros.svh
// Assertion macros for the checker file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VQBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VQBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/vqbd_pkg.sv
// Shared constants, codes and helpers for the VQ block decoder.
// No dependencies; imported by the core.
`timescale 1ns / 1ps
`default_nettype none

package vqbd_pkg;

  localparam int CODES          = 256;
  localparam int MAX_BLOCK_SIDE = 8;
  localparam int MAX_IMAGE_SIDE = 4096;
  localparam int ENTRY_WORDS    = MAX_BLOCK_SIDE * MAX_BLOCK_SIDE;

  localparam int CODE_W  = $clog2(CODES);
  localparam int OFF_W   = $clog2(ENTRY_WORDS);
  localparam int CB_AW   = CODE_W + OFF_W;
  localparam int CB_DEPTH = CODES * ENTRY_WORDS;
  localparam int WORD_W  = 24;

  localparam int IMG_W   = 13;  // image size register width
  localparam int BS_W    = 4;   // block size register width
  localparam int POS_W   = 12;  // block column / row counter width
  localparam int SIDE_W  = 3;   // dx / dy counter width
  localparam int ORG_W   = 15;  // block origin, counter times block side
  localparam int PADDR_W = 24;
  localparam int PROD_W  = 2 * IMG_W;

  localparam logic [IMG_W-1:0] IMG_MAX = IMG_W'(MAX_IMAGE_SIDE);
  localparam logic [BS_W-1:0]  BS_MAX  = BS_W'(MAX_BLOCK_SIDE);

  // Configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLOCK_WIDTH  = 2'd2;
  localparam logic [1:0] REG_BLOCK_HEIGHT = 2'd3;

  localparam logic [IMG_W-1:0] IMAGE_WIDTH_RST  = IMG_W'(64);
  localparam logic [IMG_W-1:0] IMAGE_HEIGHT_RST = IMG_W'(64);
  localparam logic [BS_W-1:0]  BLOCK_WIDTH_RST  = BS_W'(4);
  localparam logic [BS_W-1:0]  BLOCK_HEIGHT_RST = BS_W'(4);

  // Input word actions
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  function automatic logic [IMG_W-1:0] clamp_img(input logic [IMG_W-1:0] v);
    logic [IMG_W-1:0] r;
    if (v == '0)
      r = IMG_W'(1);
    else if (v > IMG_MAX)
      r = IMG_MAX;
    else
      r = v;
    return r;
  endfunction

  function automatic logic [BS_W-1:0] clamp_bs(input logic [BS_W-1:0] v);
    logic [BS_W-1:0] r;
    if (v == '0)
      r = BS_W'(1);
    else if (v > BS_MAX)
      r = BS_MAX;
    else
      r = v;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/vqbd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vqbd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: src/vq_block_decoder_core.sv
// VQ block decoder core: codebook RAM, block sequencer, shared multiplier.
// Depends on vqbd_pkg and vqbd_ram.
//
//  channel  | handshake              | fields
//  ---------+------------------------+-------------------------------------------
//  input    | start && !busy         | in_action, in_code_index, in_pixel_offset,
//           |                        | in_red_in, in_green_in, in_blue_in
//  result   | out_strobe (one cycle) | out_pixel_address, out_red_out,
//           |                        | out_green_out, out_blue_out, out_last
//  config   | cfg_we                 | cfg_addr, cfg_wdata
//
// A load word leaves the core idle and gives no result. A decode word keeps
// the core busy through four setup steps (X, Y, CHK, BASE), three of which
// share one 13x13 multiplier for the block origin and column base, then one
// codebook read per pixel of the block inside the image (16 for a full 4x4
// block); each pixel appears in the cycle after its read. Reset is synchronous,
// clears the block position and sets the configuration registers to their
// defaults; the codebook is not cleared. The receiver cannot stall, so results never wait.
`timescale 1ns / 1ps
`default_nettype none

module vq_block_decoder_core
  import vqbd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic                in_action,
  input  wire logic [7:0]          in_code_index,
  input  wire logic [5:0]          in_pixel_offset,
  input  wire logic [7:0]          in_red_in,
  input  wire logic [7:0]          in_green_in,
  input  wire logic [7:0]          in_blue_in,
  output      logic                out_strobe,
  output      logic [PADDR_W-1:0]  out_pixel_address,
  output      logic [7:0]          out_red_out,
  output      logic [7:0]          out_green_out,
  output      logic [7:0]          out_blue_out,
  output      logic                out_last,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_addr,
  input  wire logic [IMG_W-1:0]    cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_X, ST_Y, ST_CHK, ST_BASE, ST_RUN
  } state_t;

  state_t              state_r, state_nxt;
  logic [IMG_W-1:0]    iw_reg_r, iw_reg_nxt, ih_reg_r, ih_reg_nxt;
  logic [BS_W-1:0]     bw_reg_r, bw_reg_nxt, bh_reg_r, bh_reg_nxt;
  logic [POS_W-1:0]    bc_r, bc_nxt, br_r, br_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic [ORG_W-1:0]    x0_r, x0_nxt, y0_r, y0_nxt;
  logic [BS_W-1:0]     ex_r, ex_nxt, ey_r, ey_nxt;
  logic [PADDR_W-1:0]  colbase_r, colbase_nxt;
  logic [IMG_W-1:0]    ycur_r, ycur_nxt;
  logic [SIDE_W-1:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt, offcol_r, offcol_nxt;
  logic                pend_r, pend_nxt;
  logic [PADDR_W-1:0]  paddr_r, paddr_nxt;
  logic                plast_r, plast_nxt;

  logic [IMG_W-1:0]    iw, ih, rem_x, rem_y;
  logic [BS_W-1:0]     bw, bh;
  logic [IMG_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  logic                dx_end, dy_end, x_end, y_end;
  logic                accept, cb_we, cb_re;
  logic [CB_AW-1:0]    cb_waddr, cb_raddr;
  logic [WORD_W-1:0]   cb_wdata, cb_rdata;

  assign iw = clamp_img(iw_reg_r);
  assign ih = clamp_img(ih_reg_r);
  assign bw = clamp_bs(bw_reg_r);
  assign bh = clamp_bs(bh_reg_r);

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Shared multiplier: block origin x, block origin y, then column base.
  always_comb begin
    unique case (state_r)
      ST_X: begin
        mul_a = IMG_W'(bc_r);
        mul_b = IMG_W'(bw);
      end
      ST_Y: begin
        mul_a = IMG_W'(br_r);
        mul_b = IMG_W'(bh);
      end
      default: begin
        mul_a = x0_r[IMG_W-1:0];
        mul_b = ih;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign rem_x  = iw - x0_r[IMG_W-1:0];
  assign rem_y  = ih - y0_r[IMG_W-1:0];
  assign dx_end = (BS_W'(dx_r) + BS_W'(1)) == ex_r;
  assign dy_end = (BS_W'(dy_r) + BS_W'(1)) == ey_r;
  assign x_end  = (ORG_W'(x0_r) + ORG_W'(bw)) >= ORG_W'(iw);
  assign y_end  = (ORG_W'(y0_r) + ORG_W'(bh)) >= ORG_W'(ih);

  // Codebook write on an accepted load word
  assign cb_we    = accept && (in_action == ACT_LOAD)
                    && ({1'b0, in_pixel_offset} < 7'(ENTRY_WORDS));
  assign cb_waddr = {in_code_index[CODE_W-1:0], in_pixel_offset[OFF_W-1:0]};
  assign cb_wdata = {in_red_in, in_green_in, in_blue_in};
  assign cb_re    = (state_r == ST_RUN);
  assign cb_raddr = {code_r, off_r};

  vqbd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CB_DEPTH)
  ) u_codebook (
    .clk   (clk),
    .we    (cb_we),
    .waddr (cb_waddr),
    .wdata (cb_wdata),
    .re    (cb_re),
    .raddr (cb_raddr),
    .rdata (cb_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    iw_reg_nxt  = iw_reg_r;
    ih_reg_nxt  = ih_reg_r;
    bw_reg_nxt  = bw_reg_r;
    bh_reg_nxt  = bh_reg_r;
    bc_nxt      = bc_r;
    br_nxt      = br_r;
    code_nxt    = code_r;
    x0_nxt      = x0_r;
    y0_nxt      = y0_r;
    ex_nxt      = ex_r;
    ey_nxt      = ey_r;
    colbase_nxt = colbase_r;
    ycur_nxt    = ycur_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    off_nxt     = off_r;
    offcol_nxt  = offcol_r;
    pend_nxt    = 1'b0;
    paddr_nxt   = paddr_r;
    plast_nxt   = plast_r;

    if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  iw_reg_nxt = cfg_wdata;
        REG_IMAGE_HEIGHT: ih_reg_nxt = cfg_wdata;
        REG_BLOCK_WIDTH:  bw_reg_nxt = cfg_wdata[BS_W-1:0];
        REG_BLOCK_HEIGHT: bh_reg_nxt = cfg_wdata[BS_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_action == ACT_DECODE)) begin
          code_nxt  = in_code_index[CODE_W-1:0];
          state_nxt = ST_X;
        end
      end
      ST_X: begin
        x0_nxt    = prod[ORG_W-1:0];
        state_nxt = ST_Y;
      end
      ST_Y: begin
        y0_nxt    = prod[ORG_W-1:0];
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // restart at the first block when the grid shrank under us
        if ((x0_r >= ORG_W'(iw)) || (y0_r >= ORG_W'(ih))) begin
          bc_nxt = '0;
          br_nxt = '0;
          x0_nxt = '0;
          y0_nxt = '0;
        end
        state_nxt = ST_BASE;
      end
      ST_BASE: begin
        colbase_nxt = prod[PADDR_W-1:0];
        ex_nxt      = (rem_x < IMG_W'(bw)) ? rem_x[BS_W-1:0] : bw;
        ey_nxt      = (rem_y < IMG_W'(bh)) ? rem_y[BS_W-1:0] : bh;
        dx_nxt      = '0;
        dy_nxt      = '0;
        off_nxt     = '0;
        offcol_nxt  = '0;
        ycur_nxt    = y0_r[IMG_W-1:0];
        // advance block position, row fastest
        if (y_end) begin
          br_nxt = '0;
          bc_nxt = x_end ? '0 : bc_r + POS_W'(1);
        end else begin
          br_nxt = br_r + POS_W'(1);
        end
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        pend_nxt  = 1'b1;
        paddr_nxt = colbase_r + PADDR_W'(ycur_r);
        plast_nxt = dx_end && dy_end;
        if (dy_end) begin
          dy_nxt      = '0;
          dx_nxt      = dx_r + SIDE_W'(1);
          ycur_nxt    = y0_r[IMG_W-1:0];
          colbase_nxt = colbase_r + PADDR_W'(ih);
          offcol_nxt  = OFF_W'(7'(offcol_r) + 7'(bh));
          off_nxt     = OFF_W'(7'(offcol_r) + 7'(bh));
          if (dx_end) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          dy_nxt   = dy_r + SIDE_W'(1);
          ycur_nxt = ycur_r + IMG_W'(1);
          off_nxt  = off_r + OFF_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      iw_reg_r <= IMAGE_WIDTH_RST;
      ih_reg_r <= IMAGE_HEIGHT_RST;
      bw_reg_r <= BLOCK_WIDTH_RST;
      bh_reg_r <= BLOCK_HEIGHT_RST;
      bc_r     <= '0;
      br_r     <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      iw_reg_r <= iw_reg_nxt;
      ih_reg_r <= ih_reg_nxt;
      bw_reg_r <= bw_reg_nxt;
      bh_reg_r <= bh_reg_nxt;
      bc_r     <= bc_nxt;
      br_r     <= br_nxt;
      pend_r   <= pend_nxt;
    end
    code_r    <= code_nxt;
    x0_r      <= x0_nxt;
    y0_r      <= y0_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    colbase_r <= colbase_nxt;
    ycur_r    <= ycur_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    off_r     <= off_nxt;
    offcol_r  <= offcol_nxt;
    paddr_r   <= paddr_nxt;
    plast_r   <= plast_nxt;
  end

  assign out_strobe        = pend_r;
  assign out_pixel_address = paddr_r;
  assign out_last          = plast_r && pend_r;
  assign out_red_out       = cb_rdata[23:16];
  assign out_green_out     = cb_rdata[15:8];
  assign out_blue_out      = cb_rdata[7:0];

endmodule

`default_nettype wire

FILE: src/vqbd_checker.sv
// Port-level checker for the VQ block decoder core, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vqbd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_action,
  input wire logic out_strobe,
  input wire logic out_last
);

  `VQBD_ASSERT_NXT(a_load_one_cycle, start && !busy && !in_action, !busy, "load word left core busy")
  `VQBD_ASSERT_NXT(a_decode_busy, start && !busy && in_action, busy, "decode word did not raise busy")
  `VQBD_ASSERT_IMP(a_last_strobed, out_last, out_strobe, "last mark without strobe")
  `VQBD_ASSERT_NXT(a_gap_after_last, out_strobe && out_last, !out_strobe, "result right after last")
  `VQBD_ASSERT_IMP(a_idle_ends_block, $past(rst_n) && $fell(busy), out_strobe && out_last, "block ended without last word")

endmodule

bind vq_block_decoder_core vqbd_checker u_vqbd_checker (.*);

`default_nettype wire

FILE: test/tb_vq_block_decoder_core.sv
// Self-checking testbench for vq_block_decoder_core: codebook loads, block decodes, edge clipping.
// Holds its own model of the codebook and block walk. Needs vqbd_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_vq_block_decoder_core;
  import vqbd_pkg::*;

  localparam int RUN_LIMIT = 500000;
  localparam int FIXED     = 8;
  localparam int SETTLE    = 8;

  typedef struct {
    logic [23:0] addr;
    logic [23:0] rgb;
    logic        last;
  } pixel_t;

  typedef struct {
    logic        act;
    logic [7:0]  code;
    logic [5:0]  off;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    bit          typed;
    logic [23:0] addr;
    logic [23:0] rgb;
  } word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_action = 1'b0;
  logic [7:0]         in_code_index = '0;
  logic [5:0]         in_pixel_offset = '0;
  logic [7:0]         in_red_in = '0;
  logic [7:0]         in_green_in = '0;
  logic [7:0]         in_blue_in = '0;
  logic               out_strobe;
  logic [PADDR_W-1:0] out_pixel_address;
  logic [7:0]         out_red_out;
  logic [7:0]         out_green_out;
  logic [7:0]         out_blue_out;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_addr = '0;
  logic [IMG_W-1:0]   cfg_wdata = '0;

  vq_block_decoder_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_code_index    (in_code_index),
    .in_pixel_offset  (in_pixel_offset),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .out_strobe       (out_strobe),
    .out_pixel_address(out_pixel_address),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Block decoder model: codebook, register copies, block position
  logic [23:0]  cb [CODES][ENTRY_WORDS];
  bit           cb_written [CODES][ENTRY_WORDS];
  logic [12:0]  reg_iw, reg_ih;
  logic [3:0]   reg_bw, reg_bh;
  int unsigned  eff_iw, eff_ih, eff_bw, eff_bh, grid_cols, grid_rows;
  int unsigned  blk_col, blk_row;
  pixel_t       block_pixels [$];
  pixel_t       pixels_due [$];

  int  mismatches = 0;
  int  n_words = 0;
  int  n_decodes = 0;
  int  n_pixels = 0;
  int  n_settings = 0;
  int  cycle_count = 0;
  bit  burst = 1'b0;

  function automatic int unsigned fit(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic void refresh_geometry();
    eff_iw    = fit(reg_iw, MAX_IMAGE_SIDE);
    eff_ih    = fit(reg_ih, MAX_IMAGE_SIDE);
    eff_bw    = fit(reg_bw, MAX_BLOCK_SIDE);
    eff_bh    = fit(reg_bh, MAX_BLOCK_SIDE);
    grid_cols = (eff_iw + eff_bw - 1) / eff_bw;
    grid_rows = (eff_ih + eff_bh - 1) / eff_bh;
  endfunction

  function automatic void store_reg(input logic [1:0] idx, input int val);
    case (idx)
      REG_IMAGE_WIDTH:  reg_iw = 13'(val);
      REG_IMAGE_HEIGHT: reg_ih = 13'(val);
      REG_BLOCK_WIDTH:  reg_bw = 4'(val);
      REG_BLOCK_HEIGHT: reg_bh = 4'(val);
      default: ;
    endcase
    refresh_geometry();
  endfunction

  // Fill block_pixels for the next block with this code; return 1 if every
  // pixel it reads has been written.
  function automatic bit plan_block(input int unsigned code);
    int unsigned c0, r0, x, y, off;
    bit ok;
    ok = 1'b1;
    c0 = blk_col;
    r0 = blk_row;
    if (c0 >= grid_cols || r0 >= grid_rows) begin
      c0 = 0;
      r0 = 0;
    end
    block_pixels.delete();
    for (int unsigned dx = 0; dx < eff_bw; dx++) begin
      for (int unsigned dy = 0; dy < eff_bh; dy++) begin
        x = c0 * eff_bw + dx;
        y = r0 * eff_bh + dy;
        if (x < eff_iw && y < eff_ih) begin
          off = dx * eff_bh + dy;
          ok &= cb_written[code][off];
          block_pixels.push_back('{addr: 24'(x * eff_ih + y), rgb: cb[code][off], last: 1'b0});
        end
      end
    end
    if (block_pixels.size() != 0)
      block_pixels[block_pixels.size() - 1].last = 1'b1;
    return ok;
  endfunction

  function automatic void decode_block(input int unsigned code);
    if (blk_col >= grid_cols || blk_row >= grid_rows) begin
      blk_col = 0;
      blk_row = 0;
    end
    void'(plan_block(code));
    blk_row++;
    if (blk_row >= grid_rows) begin
      blk_row = 0;
      blk_col++;
      if (blk_col >= grid_cols)
        blk_col = 0;
    end
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h at cycle %0d",
             what, want, got, cycle_count);
    mismatches++;
  endtask

  task automatic send_word(input word_t w);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_action       <= w.act;
    in_code_index   <= w.code;
    in_pixel_offset <= w.off;
    in_red_in       <= w.r;
    in_green_in     <= w.g;
    in_blue_in      <= w.b;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    n_words++;
    if (w.act == ACT_LOAD) begin
      cb[w.code][w.off]         = {w.r, w.g, w.b};
      cb_written[w.code][w.off] = 1'b1;
    end else begin
      decode_block(w.code);
      n_decodes++;
      if (w.typed)
        pixels_due.push_back('{addr: w.addr, rgb: w.rgb, last: 1'b1});
      else
        foreach (block_pixels[k]) pixels_due.push_back(block_pixels[k]);
    end
  endtask

  // Hold the sender until every pending pixel has come out.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pixels_due.size() != 0);
  endtask

  task automatic set_regs(input int iw, input int ih, input int bw, input int bh);
    int          v [4];
    logic [1:0]  ids [4];
    v   = '{iw, ih, bw, bh};
    ids = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_BLOCK_WIDTH, REG_BLOCK_HEIGHT};
    cfg_we <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_addr  <= ids[k];
      cfg_wdata <= IMG_W'(v[k]);
      @(posedge clk);
      store_reg(ids[k], v[k]);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic word_t rand_word(input logic act, input int unsigned code);
    word_t w;
    w.act   = act;
    w.code  = 8'(code);
    w.off   = 6'($urandom_range(0, 63));
    w.r     = 8'($urandom_range(0, 255));
    w.g     = 8'($urandom_range(0, 255));
    w.b     = 8'($urandom_range(0, 255));
    w.typed = 1'b0;
    w.addr  = '0;
    w.rgb   = '0;
    return w;
  endfunction

  // Directed words under a 2x3 image of 1x1 blocks: one pixel per decode,
  // address walks 0..5 and wraps. Decode words carry junk load fields.
  word_t dir_words [15] = '{
    '{ACT_LOAD,   8'd0,   6'd0,  8'h00, 8'h00, 8'h00, 1'b0, 24'd0, 24'h000000},
    '{ACT_LOAD,   8'd255, 6'd0,  8'hFF, 8'hFF, 8'hFF, 1'b0, 24'd0, 24'h000000},
    '{ACT_LOAD,   8'd85,  6'd0,  8'hA5, 8'h5A, 8'h3C, 1'b0, 24'd0, 24'h000000},
    '{ACT_LOAD,   8'd170, 6'd63, 8'hC3, 8'h3C, 8'h99, 1'b0, 24'd0, 24'h000000},
    '{ACT_LOAD,   8'd170, 6'd0,  8'h01, 8'h80, 8'hFE, 1'b0, 24'd0, 24'h000000},
    '{ACT_DECODE, 8'd0,   6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'd0, 24'h000000},
    '{ACT_DECODE, 8'd255, 6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 24'd1, 24'hFFFFFF},
    '{ACT_DECODE, 8'd85,  6'd21, 8'h55, 8'hAA, 8'h0F, 1'b1, 24'd2, 24'hA55A3C},
    '{ACT_DECODE, 8'd170, 6'd42, 8'hAA, 8'h55, 8'hF0, 1'b1, 24'd3, 24'h0180FE},
    '{ACT_LOAD,   8'd255, 6'd0,  8'h7F, 8'h00, 8'hC0, 1'b0, 24'd0, 24'h000000},
    '{ACT_DECODE, 8'd255, 6'd1,  8'h12, 8'h34, 8'h56, 1'b1, 24'd4, 24'h7F00C0},
    '{ACT_DECODE, 8'd0,   6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 24'd5, 24'h000000},
    '{ACT_DECODE, 8'd255, 6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'd0, 24'h7F00C0},
    '{ACT_LOAD,   8'd170, 6'd0,  8'hFF, 8'h00, 8'hFF, 1'b0, 24'd0, 24'h000000},
    '{ACT_DECODE, 8'd170, 6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 24'd1, 24'hFF00FF}
  };

  int fixed_set [FIXED][4] = '{
    '{64, 64, 4, 4}, '{5, 7, 4, 4}, '{4096, 4096, 8, 8}, '{0, 0, 0, 0},
    '{8191, 8191, 15, 15}, '{3, 10, 8, 3}, '{4096, 1, 8, 1}, '{1, 4096, 1, 8}
  };

  initial begin : stimulus
    word_t        w;
    int           s [4];
    int           n_items, n_dec, pick, code;
    int unsigned  ready_codes [$];

    reg_iw  = IMAGE_WIDTH_RST;
    reg_ih  = IMAGE_HEIGHT_RST;
    reg_bw  = BLOCK_WIDTH_RST;
    reg_bh  = BLOCK_HEIGHT_RST;
    blk_col = 0;
    blk_row = 0;
    refresh_geometry();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    set_regs(2, 3, 1, 1);
    foreach (dir_words[i]) begin
      burst = (i < 6);
      send_word(dir_words[i]);
    end

    for (int ph = 0; ph < FIXED + 3; ph++) begin
      if (ph < FIXED) begin
        s = fixed_set[ph];
      end else if (ph == FIXED) begin
        s[0] = $urandom_range(0, 8191);
        s[1] = $urandom_range(0, 8191);
        s[2] = $urandom_range(0, 15);
        s[3] = $urandom_range(0, 15);
      end else begin
        s[0] = $urandom_range(1, 20);
        s[1] = $urandom_range(1, 20);
        s[2] = $urandom_range(1, 8);
        s[3] = $urandom_range(1, 8);
      end
      // registers change only with the core idle
      wait_drained();
      repeat (SETTLE) @(posedge clk);
      set_regs(s[0], s[1], s[2], s[3]);
      burst   = (ph % 2 == 1);
      n_items = 0;
      n_dec   = 0;
      while (n_items < 6 || n_dec < 4) begin
        if ($urandom_range(0, 15) == 0)
          wait_drained();
        ready_codes.delete();
        for (int c = 0; c < CODES; c++)
          if (plan_block(c)) ready_codes.push_back(c);
        pick = $urandom_range(0, 99);
        if (ready_codes.size() != 0 && pick < 70) begin
          w = rand_word(ACT_DECODE, ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
          send_word(w);
          n_items++;
          n_dec++;
        end else if (ready_codes.size() != 0) begin
          w = rand_word(ACT_LOAD, $urandom_range(0, CODES - 1));
          send_word(w);
          n_items++;
        end else begin
          // write a whole entry for the current block size, then decode it
          code = $urandom_range(0, CODES - 1);
          for (int o = 0; o < eff_bw * eff_bh; o++) begin
            w     = rand_word(ACT_LOAD, code);
            w.off = 6'(o);
            send_word(w);
            n_items++;
          end
          w = rand_word(ACT_DECODE, code);
          send_word(w);
          n_items++;
          n_dec++;
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d words, %0d of them block decodes, over %0d register settings.",
             n_words, n_decodes, n_settings);
    $display("Checked %0d pixels; %0d mismatches.", n_pixels, mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  always @(negedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_strobe) begin
      if (pixels_due.size() == 0) begin
        note_mismatch("pixel with none pending, address", 0, out_pixel_address);
      end else begin
        want = pixels_due.pop_front();
        n_pixels++;
        if (out_pixel_address !== want.addr)
          note_mismatch("pixel_address", want.addr, out_pixel_address);
        if (out_red_out !== want.rgb[23:16])
          note_mismatch("red_out", want.rgb[23:16], out_red_out);
        if (out_green_out !== want.rgb[15:8])
          note_mismatch("green_out", want.rgb[15:8], out_green_out);
        if (out_blue_out !== want.rgb[7:0])
          note_mismatch("blue_out", want.rgb[7:0], out_blue_out);
        if (out_last !== want.last)
          note_mismatch("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels pending.", cycle_count, pixels_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

FILE: sim.f
+incdir+src
src/vqbd_pkg.sv
src/vqbd_ram.sv
src/vq_block_decoder_core.sv
src/vqbd_checker.sv
test/tb_vq_block_decoder_core.sv
